[rtl/core/html_text_escaper_defines.svh]
// Assertion macros shared by the checker of the HTML text escaper.
`ifndef HTML_TEXT_ESCAPER_DEFINES_SVH
`define HTML_TEXT_ESCAPER_DEFINES_SVH

// Consequent holds in the same cycle as the antecedent.
`define HTE_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("hte check failed: label");

// Consequent holds in the cycle after the antecedent.
`define HTE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("hte check failed: label");

`endif

[rtl/core/hte_pkg.sv]
// Types, constants and byte functions shared by the HTML text escaper.
`default_nettype none
package hte_pkg;

	localparam int WIN_DEPTH = 6;
	localparam int WIN_SLOTS = WIN_DEPTH + 1;
	localparam int Q_DEPTH   = 4;
	localparam int Q_PTR_W   = $clog2(Q_DEPTH);

	typedef logic [WIN_SLOTS-1:0][7:0] win_t;

	localparam logic [7:0] CH_AMP = "&";
	localparam logic [7:0] CH_LT  = "<";

	// Strings are stored with their first character at index 0.
	localparam logic [6:0][7:0] PAT_OPEN  = "ferh a<";
	localparam logic [2:0][7:0] PAT_CLOSE = "a/<";
	localparam logic [3:0][7:0] ENT_LT    = ";tl&";
	localparam logic [4:0][7:0] ENT_AMP   = ";pma&";

	typedef enum logic [1:0] {
		KIND_PLAIN = 2'd0,
		KIND_LT    = 2'd1,
		KIND_AMP   = 2'd2
	} kind_t;

	typedef struct packed {
		logic [7:0] data;
		kind_t      kind;
		logic       lstep;
		logic       ltext;
	} unit_t;

	function automatic logic [7:0] fold(input logic [7:0] c);
		if (c >= "A" && c <= "Z") begin
			return c | 8'h20;
		end
		return c;
	endfunction

	// Decide how the oldest byte of b is written out; avail counts known bytes.
	function automatic kind_t classify(input win_t b, input logic [2:0] avail);
		logic open_hit;
		logic close_hit;
		open_hit  = (avail == 3'd7);
		close_hit = (avail >= 3'd3);
		for (int i = 0; i < 7; i++) begin
			if (fold(b[i]) != PAT_OPEN[i]) open_hit = 1'b0;
		end
		for (int i = 0; i < 3; i++) begin
			if (fold(b[i]) != PAT_CLOSE[i]) close_hit = 1'b0;
		end
		if (b[0] == CH_AMP) return KIND_AMP;
		if (b[0] == CH_LT && !open_hit && !close_hit) return KIND_LT;
		return KIND_PLAIN;
	endfunction

	function automatic logic [7:0] unit_byte(input unit_t u, input logic [2:0] beat);
		case (u.kind)
			KIND_AMP: return ENT_AMP[beat];
			KIND_LT:  return ENT_LT[beat[1:0]];
			default:  return u.data;
		endcase
	endfunction

	function automatic logic unit_done(input kind_t k, input logic [2:0] beat);
		case (k)
			KIND_AMP: return beat == 3'd4;
			KIND_LT:  return beat == 3'd3;
			default:  return 1'b1;
		endcase
	endfunction

endpackage
`default_nettype wire

[rtl/core/html_text_escaper.sv]
// HTML text escaper: takes one nonzero text byte per item and writes
// '&' as "&amp;" and '<' as "&lt;" unless the text at it reads "<a href" or
// "</a" (ASCII letters without regard to case). A byte is decided once six later
// bytes are known, so output lags input by up to six bytes. The input takes one
// item per cycle while s_tready is high; an item with tlast flushes the window,
// holding s_tready low while its held bytes (up to seven) enter a four-entry
// queue as units. The output side sends one byte per cycle while m_tready
// allows, so an '&' becomes five bytes and an escaped '<' four; when the queue
// fills, s_tready drops. A zero byte is dropped; with tlast on an empty
// window it yields nothing. m_tuser marks the last byte caused by an input
// item, m_tlast the final byte of the text.
`default_nettype none
module html_text_escaper
	import hte_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       s_tvalid,
	output logic            s_tready,
	input  wire logic [7:0] s_tdata,   // [7:0] char_in
	input  wire logic       s_tlast,   // end_of_text
	output logic            m_tvalid,
	input  wire logic       m_tready,
	output logic [7:0]      m_tdata,   // [7:0] out_byte
	output logic            m_tlast,   // last_of_text
	output logic            m_tuser    // last_of_step
);

	logic  push;
	unit_t push_unit;
	logic  pop;
	logic  q_full;
	logic  q_empty;
	unit_t head;

	hte_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.q_full    (q_full),
		.push      (push),
		.push_unit (push_unit)
	);

	hte_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_unit (push_unit),
		.pop       (pop),
		.full      (q_full),
		.empty     (q_empty),
		.head      (head)
	);

	hte_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_empty  (q_empty),
		.head     (head),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

endmodule
`default_nettype wire

[rtl/core/hte_front.sv]
// Front end: lookahead window, unit classification and end-of-text flush.
`default_nettype none
module hte_front
	import hte_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       s_tvalid,
	output logic            s_tready,
	input  wire logic [7:0] s_tdata,   // [7:0] char_in
	input  wire logic       s_tlast,   // end_of_text
	input  wire logic       q_full,
	output logic            push,
	output unit_t           push_unit
);

	typedef enum logic [1:0] {
		ST_TAKE  = 2'b01,
		ST_FLUSH = 2'b10
	} front_state_t;

	front_state_t state_q;
	logic [2:0]   cnt_q;
	win_t         win_q;

	logic       take;
	logic       nz;
	logic       flushing;
	logic [2:0] flush_cnt;
	win_t       cls_buf;
	logic [2:0] cls_avail;

	always_comb begin
		flushing  = (state_q == ST_FLUSH);
		s_tready  = !flushing && !q_full;
		take      = s_tvalid && s_tready;
		nz        = (s_tdata != 8'd0);
		flush_cnt = cnt_q + {2'b00, nz};
		cls_buf   = flushing ? win_q : {s_tdata, win_q[WIN_DEPTH-1:0]};
		cls_avail = flushing ? cnt_q : 3'(WIN_SLOTS);
		push      = flushing ? !q_full
		                     : (take && !s_tlast && nz && cnt_q == 3'(WIN_DEPTH));
		push_unit.data  = cls_buf[0];
		push_unit.kind  = classify(cls_buf, cls_avail);
		push_unit.lstep = !flushing || cnt_q == 3'd1;
		push_unit.ltext = flushing && cnt_q == 3'd1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_TAKE;
			cnt_q   <= 3'd0;
		end else begin
			case (state_q)
				ST_TAKE: begin
					if (take && s_tlast) begin
						cnt_q <= flush_cnt;
						if (flush_cnt != 3'd0) state_q <= ST_FLUSH;
					end else if (take && nz && cnt_q != 3'(WIN_DEPTH)) begin
						cnt_q <= cnt_q + 3'd1;
					end
				end
				ST_FLUSH: begin
					if (!q_full) begin
						cnt_q <= cnt_q - 3'd1;
						if (cnt_q == 3'd1) state_q <= ST_TAKE;
					end
				end
				default: begin
					state_q <= ST_TAKE;
					cnt_q   <= 3'd0;
				end
			endcase
		end
	end

	// Window bytes carry no reset: slots at or above the count are never used.
	always_ff @(posedge clk) begin
		if (flushing) begin
			if (!q_full) win_q[WIN_SLOTS-2:0] <= win_q[WIN_SLOTS-1:1];
		end else if (take && nz) begin
			if (!s_tlast && cnt_q == 3'(WIN_DEPTH)) begin
				win_q[WIN_DEPTH-2:0]   <= win_q[WIN_DEPTH-1:1];
				win_q[WIN_DEPTH-1]     <= s_tdata;
			end else begin
				win_q[cnt_q] <= s_tdata;
			end
		end
	end

endmodule
`default_nettype wire

[rtl/core/hte_fifo.sv]
// Short queue of classified units between front and back end.
`default_nettype none
module hte_fifo
	import hte_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  push,
	input  wire unit_t push_unit,
	input  wire logic  pop,
	output logic       full,
	output logic       empty,
	output unit_t      head
);

	unit_t              mem_q [Q_DEPTH];
	logic [Q_PTR_W-1:0] wr_q;
	logic [Q_PTR_W-1:0] rd_q;
	logic [Q_PTR_W:0]   cnt_q;

	assign full  = (cnt_q == (Q_PTR_W+1)'(Q_DEPTH));
	assign empty = (cnt_q == '0);
	assign head  = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + Q_PTR_W'(1);
			if (pop)  rd_q <= rd_q + Q_PTR_W'(1);
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + (Q_PTR_W+1)'(1);
				2'b01:   cnt_q <= cnt_q - (Q_PTR_W+1)'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_unit;
	end

endmodule
`default_nettype wire

[rtl/core/hte_back.sv]
// Back end: expands each unit into its output bytes behind an output register.
`default_nettype none
module hte_back
	import hte_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       q_empty,
	input  wire unit_t      head,
	output logic            pop,
	output logic            m_tvalid,
	input  wire logic       m_tready,
	output logic [7:0]      m_tdata,   // [7:0] out_byte
	output logic            m_tlast,   // last_of_text
	output logic            m_tuser    // last_of_step
);

	logic [2:0] beat_q;
	logic       load;
	logic       done;

	always_comb begin
		load = !q_empty && (!m_tvalid || m_tready);
		done = unit_done(head.kind, beat_q);
		pop  = load && done;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
			beat_q   <= 3'd0;
		end else begin
			if (load) begin
				m_tvalid <= 1'b1;
				beat_q   <= done ? 3'd0 : beat_q + 3'd1;
			end else if (m_tready) begin
				m_tvalid <= 1'b0;
			end
		end
	end

	// Flags ride only on the final byte of a unit.
	always_ff @(posedge clk) begin
		if (load) begin
			m_tdata <= unit_byte(head, beat_q);
			m_tuser <= done && head.lstep;
			m_tlast <= done && head.ltext;
		end
	end

endmodule
`default_nettype wire

[rtl/core/hte_checker.sv]
// Port-level checks for the HTML text escaper and their bind.
`default_nettype none
`include "html_text_escaper_defines.svh"
module hte_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       s_tvalid,
	input wire logic       s_tready,
	input wire logic [7:0] s_tdata,
	input wire logic       s_tlast,
	input wire logic       m_tvalid,
	input wire logic       m_tready,
	input wire logic [7:0] m_tdata,
	input wire logic       m_tlast,
	input wire logic       m_tuser
);

	`HTE_ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid)
	`HTE_ASSERT_NOW(a_out_nonzero, clk, arst_n, m_tvalid, m_tdata != 8'd0)
	`HTE_ASSERT_NOW(a_text_end_ends_step, clk, arst_n, m_tvalid && m_tlast, m_tuser)
	`HTE_ASSERT_NEXT(a_flush_stalls, clk, arst_n,
		s_tvalid && s_tready && s_tlast && s_tdata != 8'd0, !s_tready)

endmodule

bind html_text_escaper hte_checker u_hte_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tdata  (s_tdata),
	.s_tlast  (s_tlast),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast),
	.m_tuser  (m_tuser)
);
`default_nettype wire

[sim/html_text_escaper_tb.sv]
// Self-checking testbench for html_text_escaper: directed texts, random texts, full-rate stream.
module html_text_escaper_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WINDOW_BYTES = 6;
	localparam int QUIET_LIMIT  = 1000;
	localparam int DRAIN_CYCLES = 20;
	localparam int RANDOM_ITEMS = 300;
	localparam int TOTAL_ITEMS  = 370;

	localparam logic [7:0] AMP_CHAR = "&";
	localparam logic [7:0] LT_CHAR  = "<";
	localparam logic [7:0] NUL_CHAR = 8'h00;
	localparam string OPEN_TAG   = "<a href";
	localparam string CLOSE_TAG  = "</a";
	localparam string LT_ENTITY  = "&lt;";
	localparam string AMP_ENTITY = "&amp;";

	typedef struct packed {
		logic [7:0] out_byte;
		logic       last_of_step;
		logic       last_of_text;
	} esc_beat_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       s_tvalid = 1'b0;
	logic       s_tready;
	logic [7:0] s_tdata = 8'h00;
	logic       s_tlast = 1'b0;
	logic       m_tvalid;
	logic       m_tready = 1'b0;
	logic [7:0] m_tdata;
	logic       m_tlast;
	logic       m_tuser;

	// predictor state: undecided text bytes, oldest first, plus one slot for the new byte
	logic [7:0] text_win [0:WINDOW_BYTES];
	int         win_fill = 0;
	logic [7:0] unit_bytes [$];
	esc_beat_t  expected_bytes [$];
	logic [7:0] text_buf [$];

	bit idle_en = 1'b1;
	int stall_left = 0;
	int err_cnt = 0;
	int items_sent = 0;
	int texts_sent = 0;
	int bytes_checked = 0;
	int quiet_cycles = 0;

	html_text_escaper dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic logic [7:0] lower_ascii(input logic [7:0] c);
		if (c >= "A" && c <= "Z") begin
			return c + 8'd32;
		end
		return c;
	endfunction

	function automatic bit tag_at(input int pos, input int avail, input string tag);
		if (avail < tag.len()) return 1'b0;
		for (int i = 0; i < tag.len(); i++) begin
			if (lower_ascii(text_win[pos + i]) != lower_ascii(tag[i])) return 1'b0;
		end
		return 1'b1;
	endfunction

	// Append the escaped form of the byte at pos; avail counts it and the known bytes after it.
	function automatic void append_escaped(input int pos, input int avail);
		logic [7:0] c;
		string ent;
		c = text_win[pos];
		ent = "";
		if (c == AMP_CHAR) begin
			ent = AMP_ENTITY;
		end else if (c == LT_CHAR && !tag_at(pos, avail, OPEN_TAG) &&
				!tag_at(pos, avail, CLOSE_TAG)) begin
			ent = LT_ENTITY;
		end
		if (ent.len() == 0) begin
			unit_bytes.push_back(c);
		end else begin
			for (int i = 0; i < ent.len(); i++) unit_bytes.push_back(ent[i]);
		end
	endfunction

	function automatic void predict_escape(input logic [7:0] c, input logic eot);
		int n;
		esc_beat_t beat;
		unit_bytes.delete();
		// drop a zero byte; it only takes part through its end-of-text mark
		if (c != NUL_CHAR) begin
			text_win[win_fill] = c;
			win_fill++;
		end
		if (!eot) begin
			if (win_fill == WINDOW_BYTES + 1) begin
				append_escaped(0, win_fill);
				for (int i = 0; i < WINDOW_BYTES; i++) text_win[i] = text_win[i + 1];
				win_fill = WINDOW_BYTES;
			end
		end else begin
			for (int i = 0; i < win_fill; i++) append_escaped(i, win_fill - i);
			win_fill = 0;
		end
		n = unit_bytes.size();
		for (int i = 0; i < n; i++) begin
			beat.out_byte     = unit_bytes[i];
			beat.last_of_step = (i == n - 1);
			beat.last_of_text = eot && (i == n - 1);
			expected_bytes.push_back(beat);
		end
	endfunction

	// Predict on accepted input first, then check accepted output, all at the rising edge.
	always @(posedge clk) begin
		esc_beat_t want;
		bit moved;
		moved = 1'b0;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				predict_escape(s_tdata, s_tlast);
				moved = 1'b1;
			end
			if (m_tvalid && m_tready) begin
				moved = 1'b1;
				if (expected_bytes.size() == 0) begin
					$error("unexpected output byte %02h", m_tdata);
					err_cnt++;
				end else begin
					want = expected_bytes.pop_front();
					bytes_checked++;
					if (m_tdata !== want.out_byte) begin
						$error("out_byte: expected %02h, got %02h", want.out_byte, m_tdata);
						err_cnt++;
					end
					if (m_tuser !== want.last_of_step) begin
						$error("last_of_step: expected %0b, got %0b", want.last_of_step, m_tuser);
						err_cnt++;
					end
					if (m_tlast !== want.last_of_text) begin
						$error("last_of_text: expected %0b, got %0b", want.last_of_text, m_tlast);
						err_cnt++;
					end
				end
			end
			quiet_cycles = moved ? 0 : quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$error("no item moved for %0d cycles", QUIET_LIMIT);
				$display("html_text_escaper_tb failed");
				$finish;
			end
		end
	end

	// Output back-pressure in random bursts.
	always @(negedge clk) begin
		if (stall_left > 0) begin
			m_tready <= 1'b0;
			stall_left = stall_left - 1;
		end else if (idle_en && $urandom_range(0, 5) == 0) begin
			m_tready <= 1'b0;
			stall_left = $urandom_range(0, 9);
		end else begin
			m_tready <= 1'b1;
		end
	end

	// Enter at a falling edge; return at the falling edge after the item is taken.
	task automatic send_item(input logic [7:0] c, input logic eot);
		if (idle_en && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= c;
		s_tlast  <= eot;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic send_str(input string s, input bit close_text);
		for (int i = 0; i < s.len(); i++) begin
			send_item(s[i], close_text && (i == s.len() - 1));
		end
		if (close_text) texts_sent++;
	endtask

	function automatic logic [7:0] random_case(input logic [7:0] c);
		if (c >= "a" && c <= "z" && $urandom_range(0, 1) == 1) return c - 8'd32;
		return c;
	endfunction

	// Build a text rich in tag fragments, entities and plain bytes.
	function automatic void build_random_text(input int target_len);
		string frag;
		int cut;
		text_buf.delete();
		while (text_buf.size() < target_len) begin
			frag = "";
			case ($urandom_range(0, 11))
				0, 1: frag = OPEN_TAG;
				2:    frag = CLOSE_TAG;
				3:    text_buf.push_back(AMP_CHAR);
				4:    text_buf.push_back(LT_CHAR);
				default: begin
					if ($urandom_range(0, 19) == 0) text_buf.push_back(NUL_CHAR);
					else if ($urandom_range(0, 1) == 1) text_buf.push_back(8'($urandom_range(1, 255)));
					else text_buf.push_back(8'($urandom_range(32, 126)));
				end
			endcase
			if (frag.len() != 0) begin
				// cut some fragments short so near-misses show up
				cut = frag.len();
				if ($urandom_range(0, 3) == 0) cut = $urandom_range(1, frag.len());
				for (int i = 0; i < cut; i++) text_buf.push_back(random_case(frag[i]));
			end
		end
	endfunction

	task automatic send_random_text();
		int len;
		len = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 30) : $urandom_range(1, 16);
		build_random_text(len);
		for (int i = 0; i < text_buf.size(); i++) begin
			send_item(text_buf[i], i == text_buf.size() - 1);
		end
		texts_sent++;
		// an end-of-text mark with nothing held
		if ($urandom_range(0, 7) == 0) send_item(NUL_CHAR, 1'b1);
	endtask

	task automatic test_directed();
		send_str("<A HrEf&", 1'b1);
		send_str("</a", 1'b0);
		send_item(NUL_CHAR, 1'b1);
		send_str("<a hre", 1'b1);
		send_item(8'h01, 1'b0);
		send_item(NUL_CHAR, 1'b0);
		send_item(8'hFF, 1'b1);
		send_item(NUL_CHAR, 1'b1);
		send_str("<", 1'b1);
	endtask

	task automatic test_random_texts();
		while (items_sent < RANDOM_ITEMS) begin
			idle_en = ($urandom_range(0, 3) != 0);
			send_random_text();
		end
	endtask

	task automatic test_full_rate();
		idle_en = 1'b0;
		while (items_sent < TOTAL_ITEMS) send_random_text();
	endtask

	initial begin
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_directed();
		test_random_texts();
		test_full_rate();
		s_tvalid <= 1'b0;
		while (expected_bytes.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Sent %0d text bytes in %0d texts; checked %0d escaped output bytes.",
			items_sent, texts_sent, bytes_checked);
		$display("Covered tag matches, near-misses, short tails, zero bytes and stalls.");
		if (err_cnt == 0) begin
			$display("html_text_escaper_tb passed");
		end else begin
			$display("html_text_escaper_tb failed");
		end
		$finish;
	end

endmodule
